@@ hw/rtl/bdll_pkg.sv @@
package bdll_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD_HEAD  = 3'd0;
    localparam logic [2:0] CMD_ADD_TAIL  = 3'd1;
    localparam logic [2:0] CMD_ADD_AFTER = 3'd2;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd3;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd4;
    localparam logic [2:0] CMD_DELETE    = 3'd5;
    localparam logic [2:0] CMD_EXISTS    = 3'd6;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] anchor;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               found;
        logic [6:0]         count;
    } t_out;

endpackage

@@ hw/rtl/bdll_ram.sv @@
module bdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bounded_doubly_linked_list.sv @@
// Ordered list of signed values kept in a fixed pool of CAPACITY nodes, each
// with a value, a forward link and a backward link; unused nodes form a free
// list. One request is taken at a time: o_in_stall is high from acceptance
// until the result has been loaded into the output register, which holds it
// while the receiver stalls. After reset the block first chains the free list
// through the forward-link memory and takes no request meanwhile. Add at head
// or tail passes through S_AW1 and S_AW2 before the result; pop head or tail
// reads the node in S_URD, then updates links in S_UW1, S_UW2 and S_UW3. Add
// after anchor, delete and exists walk the list from the head one node per
// cycle through the single read port of the three link and value memories,
// visiting at most CAPACITY nodes, before the add or unlink writes. Empty and
// full errors go straight to the result; not found is known once the walk ends.
module bounded_doubly_linked_list #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bdll_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bdll_pkg::t_out     o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] NONE = IW'(CAPACITY);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FIND, S_AW1, S_AW2, S_URD, S_UW1, S_UW2, S_UW3, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HEAD, OP_TAIL, OP_AFTER
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [2:0]            r_cmd;
    logic [VALUE_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [IW-1:0]         r_head;
    logic [IW-1:0]         r_tail;
    logic [IW-1:0]         r_fh;
    logic [IW-1:0]         r_nfh;
    logic [IW-1:0]         r_count;
    logic [IW-1:0]         r_cur;
    logic [IW-1:0]         r_steps;
    logic [IW-1:0]         r_p;
    logic [IW-1:0]         r_nx;
    logic [1:0]            r_status;
    logic [31:0]           r_data;
    logic                  r_found;
    logic                  r_ovalid;
    bdll_pkg::t_out        r_out;

    // memory ports
    logic [AW-1:0]         rd_addr;
    logic                  val_we;
    logic [AW-1:0]         val_wa;
    logic [VALUE_BITS-1:0] val_wd;
    logic [VALUE_BITS-1:0] val_rdata;
    logic                  next_we;
    logic [AW-1:0]         next_wa;
    logic [IW-1:0]         next_wd;
    logic [IW-1:0]         next_rdata;
    logic                  prev_we;
    logic [AW-1:0]         prev_wa;
    logic [IW-1:0]         prev_wd;
    logic [IW-1:0]         prev_rdata;

    logic          hit;
    logic          stop;
    logic          full;
    logic          empty;
    logic          head_cut;
    logic          tail_cut;
    logic [IW-1:0] head_new;
    logic [IW-1:0] tail_new;
    logic [IW-1:0] tail_fix;

    bdll_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(rd_addr), .o_rdata(val_rdata)
    );

    bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(rd_addr), .o_rdata(next_rdata)
    );

    bdll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(rd_addr), .o_rdata(prev_rdata)
    );

    assign full  = (r_count >= IW'(CAPACITY)) || (r_fh >= NONE);
    assign empty = (r_head >= NONE);

    // search compare: node under the read data versus the key
    assign hit  = (val_rdata == r_key);
    assign stop = (next_rdata >= NONE) || (r_steps == LAST_STEP);

    // unlink: new head and tail after cutting node r_cur out
    assign head_cut = (r_cur == r_head) || (r_p >= NONE);
    assign head_new = head_cut ? r_nx : r_head;
    assign tail_cut = (r_cur == r_tail) || (r_nx >= NONE);
    assign tail_new = tail_cut ? ((r_cur == head_new) ? NONE : r_p) : r_tail;
    assign tail_fix = (r_head < NONE) ? r_tail : NONE;

    always_comb begin
        rd_addr = r_fh[AW-1:0];
        val_we  = 1'b0;
        val_wa  = r_fh[AW-1:0];
        val_wd  = r_val;
        next_we = 1'b0;
        next_wa = r_fh[AW-1:0];
        next_wd = NONE;
        prev_we = 1'b0;
        prev_wa = r_fh[AW-1:0];
        prev_wd = NONE;
        unique case (r_state)
            S_INIT: begin
                next_we = 1'b1;
                next_wa = r_cur[AW-1:0];
                next_wd = r_cur + 1'b1;
            end
            S_IDLE: begin
                case (i_in.cmd)
                    bdll_pkg::CMD_ADD_AFTER: rd_addr = empty ? r_fh[AW-1:0] : r_head[AW-1:0];
                    bdll_pkg::CMD_POP_TAIL:  rd_addr = r_tail[AW-1:0];
                    bdll_pkg::CMD_POP_HEAD, bdll_pkg::CMD_DELETE,
                    bdll_pkg::CMD_EXISTS:    rd_addr = r_head[AW-1:0];
                    default:                 rd_addr = r_fh[AW-1:0];
                endcase
            end
            S_FIND: begin
                // follow the forward link, or fetch the free head once done
                rd_addr = (hit || stop) ? r_fh[AW-1:0] : next_rdata[AW-1:0];
            end
            S_AW1: begin
                val_we  = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                case (r_op)
                    OP_HEAD: begin
                        next_wd = r_head;
                        prev_wd = NONE;
                    end
                    OP_TAIL: begin
                        next_wd = NONE;
                        prev_wd = r_tail;
                    end
                    default: begin
                        next_wd = r_nx;
                        prev_wd = r_cur;
                    end
                endcase
            end
            S_AW2: begin
                next_wd = r_fh;
                prev_wd = r_fh;
                case (r_op)
                    OP_HEAD: begin
                        prev_we = (r_head < NONE);
                        prev_wa = r_head[AW-1:0];
                    end
                    OP_TAIL: begin
                        next_we = (r_tail < NONE);
                        next_wa = r_tail[AW-1:0];
                    end
                    default: begin
                        prev_we = (r_nx < NONE);
                        prev_wa = r_nx[AW-1:0];
                        next_we = 1'b1;
                        next_wa = r_cur[AW-1:0];
                    end
                endcase
            end
            S_UW1: begin
                next_we = !head_cut;
                next_wa = r_p[AW-1:0];
                next_wd = r_nx;
                prev_we = !tail_cut;
                prev_wa = r_nx[AW-1:0];
                prev_wd = r_p;
            end
            S_UW2: begin
                prev_we = (r_head < NONE);
                prev_wa = r_head[AW-1:0];
                prev_wd = NONE;
                next_we = (tail_fix < NONE);
                next_wa = tail_fix[AW-1:0];
                next_wd = NONE;
            end
            S_UW3: begin
                // return the node to the free list
                next_we = 1'b1;
                next_wa = r_cur[AW-1:0];
                next_wd = r_fh;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_op     <= OP_HEAD;
            r_cur    <= '0;
            r_head   <= NONE;
            r_tail   <= NONE;
            r_fh     <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the result once the receiver takes it, unless a new one loads
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cur <= r_cur + 1'b1;
                    if (r_cur == LAST_STEP) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_in.cmd;
                        r_key    <= (i_in.cmd == bdll_pkg::CMD_ADD_AFTER)
                                    ? VALUE_BITS'(i_in.anchor) : VALUE_BITS'(i_in.value);
                        r_val    <= VALUE_BITS'(i_in.value);
                        r_status <= bdll_pkg::ST_OK;
                        r_data   <= '0;
                        r_found  <= 1'b0;
                        r_steps  <= '0;
                        r_cur    <= r_head;
                        case (i_in.cmd)
                            bdll_pkg::CMD_ADD_HEAD, bdll_pkg::CMD_ADD_TAIL,
                            bdll_pkg::CMD_ADD_AFTER: begin
                                if (full) begin
                                    r_status <= bdll_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (i_in.cmd == bdll_pkg::CMD_ADD_TAIL) begin
                                    r_op    <= OP_TAIL;
                                    r_state <= S_AW1;
                                end else if (i_in.cmd == bdll_pkg::CMD_ADD_HEAD || empty) begin
                                    r_op    <= OP_HEAD;
                                    r_state <= S_AW1;
                                end else begin
                                    r_state <= S_FIND;
                                end
                            end
                            bdll_pkg::CMD_POP_HEAD, bdll_pkg::CMD_POP_TAIL: begin
                                if (empty) begin
                                    r_status <= bdll_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    if (i_in.cmd == bdll_pkg::CMD_POP_TAIL) begin
                                        r_cur <= r_tail;
                                    end
                                    r_state <= S_URD;
                                end
                            end
                            bdll_pkg::CMD_DELETE: begin
                                if (empty) begin
                                    r_status <= bdll_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_FIND;
                                end
                            end
                            bdll_pkg::CMD_EXISTS: begin
                                r_state <= empty ? S_DONE : S_FIND;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    r_p  <= prev_rdata;
                    r_nx <= next_rdata;
                    if (hit) begin
                        case (r_cmd)
                            bdll_pkg::CMD_ADD_AFTER: begin
                                r_op    <= OP_AFTER;
                                r_state <= S_AW1;
                            end
                            bdll_pkg::CMD_DELETE: begin
                                r_state <= S_UW1;
                            end
                            default: begin
                                r_found <= 1'b1;
                                r_state <= S_DONE;
                            end
                        endcase
                    end else if (stop) begin
                        case (r_cmd)
                            bdll_pkg::CMD_ADD_AFTER: begin
                                r_op    <= OP_TAIL;
                                r_state <= S_AW1;
                            end
                            bdll_pkg::CMD_DELETE: begin
                                r_status <= bdll_pkg::ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else begin
                        // advance to the next node
                        r_cur   <= next_rdata;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_AW1: begin
                    r_nfh   <= next_rdata;
                    r_state <= S_AW2;
                end
                S_AW2: begin
                    case (r_op)
                        OP_HEAD: begin
                            if (r_head >= NONE) begin
                                r_tail <= r_fh;
                            end
                            r_head <= r_fh;
                        end
                        OP_TAIL: begin
                            if (r_tail >= NONE) begin
                                r_head <= r_fh;
                            end
                            r_tail <= r_fh;
                        end
                        default: begin
                            if (r_nx >= NONE) begin
                                r_tail <= r_fh;
                            end
                        end
                    endcase
                    r_fh    <= r_nfh;
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_URD: begin
                    r_p     <= prev_rdata;
                    r_nx    <= next_rdata;
                    r_data  <= 32'($signed(val_rdata));
                    r_state <= S_UW1;
                end
                S_UW1: begin
                    r_head  <= head_new;
                    r_tail  <= tail_new;
                    r_state <= S_UW2;
                end
                S_UW2: begin
                    r_tail  <= tail_fix;
                    r_state <= S_UW3;
                end
                S_UW3: begin
                    r_fh    <= r_cur;
                    r_count <= r_count - 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.status <= r_status;
                        r_out.data   <= r_data;
                        r_out.found  <= r_found;
                        r_out.count  <= 7'(r_count);
                        r_ovalid     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

@@ tb/sv/tb_bounded_doubly_linked_list.sv @@
module tb_bounded_doubly_linked_list;

    localparam int CAP = 64;
    localparam int NONE = CAP;
    localparam int CYCLE_LIMIT = 400000;

    // Shadow copy of the list: pool of nodes, links, free chain.
    class list_scoreboard;
        logic signed [31:0] vals[CAP];
        int nxt[CAP];
        int prv[CAP];
        int head, tail, free_head, count;
        bdll_pkg::t_out pending[$];
        int errors;

        function new();
            for (int i = 0; i < CAP; i++) begin
                nxt[i] = i + 1;
                prv[i] = 0;
                vals[i] = '0;
            end
            head = NONE;
            tail = NONE;
            free_head = 0;
            count = 0;
            errors = 0;
        endfunction

        function int find(logic signed [31:0] v);
            int cur;
            int steps;
            cur = head;
            steps = 0;
            while (cur < CAP && steps < CAP) begin
                if (vals[cur] == v) return cur;
                cur = nxt[cur];
                steps++;
            end
            return NONE;
        endfunction

        function int grab(logic signed [31:0] v);
            int n;
            n = free_head;
            free_head = nxt[n];
            vals[n] = v;
            nxt[n] = NONE;
            prv[n] = NONE;
            count++;
            return n;
        endfunction

        function void unlink(int n);
            int p;
            int nx;
            p = prv[n];
            nx = nxt[n];
            if (n == head || p >= CAP) head = nx;
            else nxt[p] = nx;
            if (n == tail || nx >= CAP) tail = (n == head) ? NONE : p;
            else prv[nx] = p;
            if (head < CAP) prv[head] = NONE;
            else tail = NONE;
            if (tail < CAP) nxt[tail] = NONE;
            nxt[n] = free_head;
            free_head = n;
            count--;
        endfunction

        // Apply one accepted request and queue the result it should give.
        function void note_request(bdll_pkg::t_in r);
            bdll_pkg::t_out e;
            int n;
            int nx;
            logic full;
            logic empty;
            e = '0;
            full = (count >= CAP) || (free_head >= CAP);
            empty = (head >= CAP);
            case (r.cmd)
                bdll_pkg::CMD_ADD_HEAD, bdll_pkg::CMD_ADD_TAIL,
                bdll_pkg::CMD_ADD_AFTER: begin
                    if (full) begin
                        e.status = bdll_pkg::ST_FULL;
                    end else if (r.cmd == bdll_pkg::CMD_ADD_HEAD
                                 || (r.cmd == bdll_pkg::CMD_ADD_AFTER && empty)) begin
                        n = grab(r.value);
                        nxt[n] = head;
                        if (head < CAP) prv[head] = n;
                        else tail = n;
                        head = n;
                    end else begin
                        n = (r.cmd == bdll_pkg::CMD_ADD_AFTER) ? find(r.anchor) : NONE;
                        if (n < CAP) begin
                            int m;
                            m = grab(r.value);
                            nx = nxt[n];
                            nxt[m] = nx;
                            prv[m] = n;
                            if (nx < CAP) prv[nx] = m;
                            else tail = m;
                            nxt[n] = m;
                        end else begin
                            n = grab(r.value);
                            prv[n] = tail;
                            if (tail < CAP) nxt[tail] = n;
                            else head = n;
                            tail = n;
                        end
                    end
                end
                bdll_pkg::CMD_POP_HEAD, bdll_pkg::CMD_POP_TAIL: begin
                    n = (r.cmd == bdll_pkg::CMD_POP_HEAD) ? head : tail;
                    if (empty || n >= CAP) begin
                        e.status = bdll_pkg::ST_EMPTY;
                    end else begin
                        e.data = vals[n];
                        unlink(n);
                    end
                end
                bdll_pkg::CMD_DELETE: begin
                    if (empty) begin
                        e.status = bdll_pkg::ST_EMPTY;
                    end else begin
                        n = find(r.value);
                        if (n >= CAP) e.status = bdll_pkg::ST_NOT_FOUND;
                        else unlink(n);
                    end
                end
                bdll_pkg::CMD_EXISTS: e.found = (find(r.value) < CAP);
                default: ;
            endcase
            e.count = count[6:0];
            pending.push_back(e);
        endfunction

        function void check_result(bdll_pkg::t_out got);
            bdll_pkg::t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.data !== e.data) begin
                $display("%0t: data exp %0d got %0d", $time, e.data, got.data);
                errors++;
            end
            if (got.found !== e.found) begin
                $display("%0t: found exp %0d got %0d", $time, e.found, got.found);
                errors++;
            end
            if (got.count !== e.count) begin
                $display("%0t: count exp %0d got %0d", $time, e.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    bdll_pkg::t_in  in_req = '0;
    logic in_stall;
    logic out_valid;
    bdll_pkg::t_out out_res;
    int   cycles = 0;
    list_scoreboard sb = new();

    // Pool of values kept small so searches, duplicates and misses all happen.
    logic signed [31:0] pool[8];

    always #6 i_clk = ~i_clk;

    bounded_doubly_linked_list i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_res)
    );

    // Note requests and check results at the edge where they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) sb.note_request(in_req);
        if (i_rst_n && out_valid && !out_stall) sb.check_result(out_res);
    end

    // Receiver: stall on its own pattern, with quiet stretches.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 2000 < 500) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one request and hold it until it is taken.
    task automatic send(logic [2:0] cmd, logic signed [31:0] anc, logic signed [31:0] v);
        bdll_pkg::t_in r;
        r.cmd = cmd;
        r.anchor = anc;
        r.value = v;
        in_req <= r;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic idle(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return pool[$urandom_range(0, 7)];
    endfunction

    task automatic random_request(int bias_add);
        int r;
        logic [2:0] cmd;
        r = $urandom_range(0, 99);
        if (r < bias_add) begin
            cmd = 3'($urandom_range(bdll_pkg::CMD_ADD_HEAD, bdll_pkg::CMD_ADD_AFTER));
        end else begin
            cmd = 3'($urandom_range(bdll_pkg::CMD_POP_HEAD, bdll_pkg::CMD_UNUSED));
        end
        send(cmd, pick(), pick());
    endtask

    initial begin
        int burst;
        int sent;
        int bias;
        pool[0] = 32'sh7fffffff;
        pool[1] = 32'sh80000000;
        pool[2] = 0;
        pool[3] = -1;
        pool[4] = 1;
        pool[5] = 32'sh55555555;
        pool[6] = 32'shaaaaaaaa;
        pool[7] = 42;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list errors, each command, extremes.
        send(bdll_pkg::CMD_POP_HEAD, 0, 0);
        send(bdll_pkg::CMD_POP_TAIL, 0, 0);
        send(bdll_pkg::CMD_DELETE, 0, 5);
        send(bdll_pkg::CMD_EXISTS, 0, 5);
        send(bdll_pkg::CMD_ADD_AFTER, 3, 32'sh7fffffff);
        send(bdll_pkg::CMD_ADD_HEAD, 0, 32'sh80000000);
        send(bdll_pkg::CMD_ADD_TAIL, 0, -1);
        send(bdll_pkg::CMD_ADD_AFTER, -1, 7);
        send(bdll_pkg::CMD_ADD_AFTER, 32'sh80000000, 8);
        send(bdll_pkg::CMD_ADD_AFTER, 99, 9);
        send(bdll_pkg::CMD_EXISTS, 0, 32'sh7fffffff);
        send(bdll_pkg::CMD_EXISTS, 0, 12345);
        send(bdll_pkg::CMD_DELETE, 0, 12345);
        send(bdll_pkg::CMD_DELETE, 0, 9);
        send(bdll_pkg::CMD_DELETE, 0, 32'sh80000000);
        send(bdll_pkg::CMD_UNUSED, 32'shffffffff, 32'shffffffff);
        send(bdll_pkg::CMD_POP_HEAD, 0, 0);
        send(bdll_pkg::CMD_POP_TAIL, 0, 0);
        // Fill to capacity, then overflow every add form.
        for (int i = 0; i < CAP; i++) send(bdll_pkg::CMD_ADD_TAIL, 0, i);
        send(bdll_pkg::CMD_ADD_HEAD, 0, 1);
        send(bdll_pkg::CMD_ADD_TAIL, 0, 1);
        send(bdll_pkg::CMD_ADD_AFTER, 63, 1);
        send(bdll_pkg::CMD_EXISTS, 0, 63);
        for (int i = 0; i < CAP; i++) send(bdll_pkg::CMD_POP_HEAD, 0, 0);

        // Random: phases that grow, churn and drain the list.
        sent = 0;
        while (sent < 300) begin
            bias = (sent / 75) % 3 == 0 ? 75 : ((sent / 75) % 3 == 1 ? 45 : 25);
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                random_request(bias);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (CAP + 10) @(posedge i_clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
